// ===== hw/rtl/msts_pkg.sv =====
// ----------------------------------------------------------------------------
// msts_pkg
// Shared types, constants and the cable code decoder for the spare length
// block.
// ----------------------------------------------------------------------------
package msts_pkg;

    localparam int LEN_W   = 6;
    localparam int TOTAL_W = 18;
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 6;

    localparam logic [LEN_W-1:0]   LONGEST   = 6'd52;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 18'h3FFFF;

    typedef struct packed {
        logic accept;
        logic start;
        logic init_step;
        logic scan_rd;
        logic advance;
        logic merge;
        logic union_step;
        logic load_out;
        logic clear_step;
    } msts_cmd_t;

    typedef struct packed {
        logic init_done;
        logic tree_full;
        logic join_ok;
        logic last_pos;
        logic scan_done;
        logic union_done;
        logic out_free;
        logic clear_done;
    } msts_sts_t;

    function automatic logic [LEN_W-1:0] code_to_length(input logic [CODE_W-1:0] code);
        logic [LEN_W-1:0] len;
        len = '0;
        if (code >= 8'h61 && code <= 8'h7A)
        begin
            len = LEN_W'(code - 8'h60);
        end
        else if (code >= 8'h41 && code <= 8'h5A)
        begin
            len = LEN_W'(code - 8'h41 + 8'd27);
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/min_spanning_tree_spare_length.sv =====
// ----------------------------------------------------------------------------
// min_spanning_tree_spare_length
// Loads a matrix of cable codes and reports the cable length left over after
// a minimum spanning tree, or that the nodes are not connected.
//
// Usage: write node_count on the cfg channel while idle. Send matrix entries
// on the input channel, one beat per cycle; beats are taken only while
// in_stall is low, and a beat whose nodes are both below node_count stores
// the entry and adds its length to the running total. The beat with
// last_entry set starts the tree search, and the input stalls until the
// block is idle again. After the last beat the block initializes the
// labels, then scans each matrix position for each weight 1..52 until the
// tree is complete, merging labels per joined edge, then clears edge memory.
// The result beat sits in an output register; a stalled receiver holds it,
// and the next result waits until it is taken.
// Reset: node_count returns to 1, totals clear, no result pending. The edge
// memory is not cleared by reset; each entry read must be written first.
// ----------------------------------------------------------------------------
module min_spanning_tree_spare_length
    import msts_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IDX_W-1:0]     from_node,
    input  logic [IDX_W-1:0]     to_node,
    input  logic [CODE_W-1:0]    length_code,
    input  logic                 last_entry,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TOTAL_W-1:0]   spare_length,
    output logic                 connected,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    msts_cmd_t cmd;
    msts_sts_t sts;

    assign cfg_ready = 1'b1;

    msts_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    msts_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .from_node    (from_node),
        .to_node      (to_node),
        .length_code  (length_code),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .spare_length (spare_length),
        .connected    (connected)
    );

endmodule

// ===== hw/rtl/msts_ctrl.sv =====
// ----------------------------------------------------------------------------
// msts_ctrl
// Sequencer: load, label init, edge scan by weight, component merge, result
// handoff and matrix clear.
// ----------------------------------------------------------------------------
module msts_ctrl
    import msts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       last_entry,
    output logic       in_stall,
    input  msts_sts_t  sts,
    output msts_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_UNION  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;
    localparam logic [2:0] ST_CLEAR  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (last_entry)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_done)
                begin
                    state_next = sts.tree_full ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.advance = 1'b1;
                if (sts.join_ok)
                begin
                    cmd.merge  = 1'b1;
                    state_next = ST_UNION;
                end
                else
                begin
                    state_next = sts.last_pos ? ST_RESULT : ST_SCAN;
                end
            end
            ST_UNION:
            begin
                cmd.union_step = 1'b1;
                if (sts.union_done)
                begin
                    state_next = (sts.tree_full || sts.scan_done) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/msts_dp.sv =====
// ----------------------------------------------------------------------------
// msts_dp
// Datapath: edge length memory, component label memory, scan counters,
// totals and the result register.
// ----------------------------------------------------------------------------
module msts_dp
    import msts_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  msts_cmd_t            cmd,
    output msts_sts_t            sts,
    input  logic [IDX_W-1:0]     from_node,
    input  logic [IDX_W-1:0]     to_node,
    input  logic [CODE_W-1:0]    length_code,
    input  logic                 cfg_valid,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [TOTAL_W-1:0]   spare_length,
    output logic                 connected
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int AW     = 2 * NODE_W;
    localparam int DEPTH  = 1 << AW;
    localparam logic [CFG_W-1:0] MAX_CFG = CFG_W'(MAX_NODES);

    logic [LEN_W-1:0]   edge_mem [DEPTH];
    logic [NODE_W-1:0]  label_mem [MAX_NODES];

    logic [CNT_W-1:0]   n_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] tree_reg;
    logic [NODE_W-1:0]  edges_reg;
    logic [LEN_W-1:0]   w_reg;
    logic [NODE_W-1:0]  i_reg;
    logic [NODE_W-1:0]  j_reg;
    logic [CNT_W-1:0]   k_reg;
    logic               pv_reg;
    logic [NODE_W-1:0]  pidx_reg;
    logic [NODE_W-1:0]  ra_reg;
    logic [NODE_W-1:0]  rb_reg;
    logic               done_reg;
    logic [AW-1:0]      clr_reg;
    logic [LEN_W-1:0]   edge_q_reg;
    logic [NODE_W-1:0]  la_q_reg;
    logic [NODE_W-1:0]  lb_q_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] spare_reg;
    logic               conn_reg;

    logic [LEN_W-1:0]   in_len;
    logic               in_range;
    logic [TOTAL_W:0]   sum;
    logic [NODE_W-1:0]  n_last;
    logic               issue;
    logic [NODE_W-1:0]  rd_a;
    logic [CFG_W-1:0]   n_ext;

    assign in_len   = code_to_length(length_code);
    assign n_ext    = CFG_W'(n_reg);
    assign in_range = ({1'b0, from_node} < n_ext) && ({1'b0, to_node} < n_ext);
    assign sum      = {1'b0, total_reg} + TOTAL_W'(in_len);
    assign n_last   = NODE_W'(n_reg - 1'b1);
    assign issue    = (k_reg < n_reg);
    assign rd_a     = cmd.union_step ? k_reg[NODE_W-1:0] : i_reg;

    assign sts.init_done  = (k_reg == CNT_W'(MAX_NODES - 1));
    assign sts.tree_full  = (edges_reg == n_last);
    assign sts.join_ok    = (edge_q_reg == w_reg) && (la_q_reg != lb_q_reg);
    assign sts.last_pos   = (j_reg == n_last) && (i_reg == n_last) && (w_reg == LONGEST);
    assign sts.scan_done  = done_reg;
    assign sts.union_done = !issue && !pv_reg;
    assign sts.out_free   = !out_valid_reg;
    assign sts.clear_done = (clr_reg == {AW{1'b1}});

    assign out_valid    = out_valid_reg;
    assign spare_length = spare_reg;
    assign connected    = conn_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            edge_mem[clr_reg] <= '0;
        end
        else if (cmd.accept && in_range)
        begin
            edge_mem[{from_node[NODE_W-1:0], to_node[NODE_W-1:0]}] <= in_len;
        end
        if (cmd.scan_rd)
        begin
            edge_q_reg <= edge_mem[{i_reg, j_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
        begin
            label_mem[k_reg[NODE_W-1:0]] <= k_reg[NODE_W-1:0];
        end
        else if (pv_reg && (la_q_reg == rb_reg))
        begin
            label_mem[pidx_reg] <= ra_reg;
        end
        la_q_reg <= label_mem[rd_a];
        lb_q_reg <= label_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            spare_reg <= (edges_reg == n_last) && (total_reg >= tree_reg)
                         ? total_reg - tree_reg : '0;
            conn_reg  <= (edges_reg == n_last) && (total_reg >= tree_reg);
        end
        if (cmd.merge)
        begin
            ra_reg <= la_q_reg;
            rb_reg <= lb_q_reg;
        end
        pidx_reg <= k_reg[NODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_W'(1);
            total_reg     <= '0;
            tree_reg      <= '0;
            edges_reg     <= '0;
            w_reg         <= LEN_W'(1);
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pv_reg        <= 1'b0;
            done_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                priority if (cfg_data == '0)
                begin
                    n_reg <= CNT_W'(1);
                end
                else if (cfg_data > MAX_CFG)
                begin
                    n_reg <= CNT_W'(MAX_NODES);
                end
                else
                begin
                    n_reg <= CNT_W'(cfg_data);
                end
            end

            if (cmd.accept && in_range)
            begin
                total_reg <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            end
            else if (cmd.load_out)
            begin
                total_reg <= '0;
            end

            if (cmd.start)
            begin
                tree_reg  <= '0;
                edges_reg <= '0;
                w_reg     <= LEN_W'(1);
                i_reg     <= '0;
                j_reg     <= '0;
                k_reg     <= '0;
                done_reg  <= 1'b0;
                clr_reg   <= '0;
            end
            else if (cmd.init_step)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (cmd.advance)
            begin
                done_reg <= sts.last_pos;
                if (j_reg == n_last)
                begin
                    j_reg <= '0;
                    if (i_reg == n_last)
                    begin
                        i_reg <= '0;
                        w_reg <= w_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end

            if (cmd.merge)
            begin
                tree_reg  <= tree_reg + TOTAL_W'(w_reg);
                edges_reg <= edges_reg + 1'b1;
                k_reg     <= '0;
            end
            else if (cmd.union_step && issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            pv_reg <= cmd.union_step && issue;

            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
